>>> hw/rtl/ngl_pkg.sv
package ngl_pkg;

	// Field and state widths
	localparam int SAMPLE_BITS   = 24;
	localparam int THR_BITS      = SAMPLE_BITS - 1;
	localparam int LEVEL_BITS    = 17;
	localparam int LEN_BITS      = 16;
	localparam int GAIN_BITS     = 32;
	localparam int GAIN_FRAC     = 30;
	localparam int LEVEL_SHIFT   = GAIN_FRAC - (LEVEL_BITS - 1);
	localparam int DIFF_BITS     = GAIN_BITS + 1;
	localparam int STEP_BITS     = $clog2(GAIN_BITS);
	localparam int PROD_BITS     = SAMPLE_BITS + 1 + GAIN_BITS - GAIN_FRAC;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// Register defaults
	localparam logic [THR_BITS-1:0]   THRESHOLD_RST = THR_BITS'(1 << (SAMPLE_BITS - 2));
	localparam logic [LEVEL_BITS-1:0] LEVEL_RST     = LEVEL_BITS'(13107);
	localparam logic [LEN_BITS-1:0]   ATTACK_RST    = LEN_BITS'(44100);
	localparam logic [LEN_BITS-1:0]   RELEASE_RST   = LEN_BITS'(44100);

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MONITOR   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO    = 3'd5;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_left;
		logic signed [SAMPLE_BITS-1:0] sample_right;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} result_t;

	// Control for the bit-serial units
	typedef struct packed {
		logic load;
		logic run;
		logic last;
	} ser_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_CROSS,
		ST_LOAD,
		ST_RUN,
		ST_FIN,
		ST_POST
	} ngl_state_t;

	// Clamp a scaled product into the sample range
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [PROD_BITS-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		r = v[SAMPLE_BITS-1:0];
		if (v > PROD_BITS'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}})))
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (v < PROD_BITS'(signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}})))
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		return r;
	endfunction

	// Clamp a grown sum into the gain range
	function automatic logic signed [GAIN_BITS-1:0] sat_gain(
		input logic signed [DIFF_BITS-1:0] v);
		logic signed [GAIN_BITS-1:0] r;
		r = v[GAIN_BITS-1:0];
		if (v[DIFF_BITS-1] != v[GAIN_BITS-1])
			r = v[DIFF_BITS-1] ? {1'b1, {(GAIN_BITS-1){1'b0}}}
			                   : {1'b0, {(GAIN_BITS-1){1'b1}}};
		return r;
	endfunction

endpackage

>>> hw/rtl/ngl_mul.sv
module ngl_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ngl_pkg::ser_ctl_t                     ctl,
	input  logic signed [ngl_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [ngl_pkg::GAIN_BITS-1:0]   gain,
	output logic signed [ngl_pkg::PROD_BITS-1:0]   prod
);
	import ngl_pkg::*;

	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic signed [SAMPLE_BITS:0]   hi_q;
	logic        [GAIN_BITS-1:0]   lo_q;
	logic signed [SAMPLE_BITS:0]   samp_ext;
	logic signed [SAMPLE_BITS:0]   addend;
	logic signed [SAMPLE_BITS:0]   sum;
	logic                          busy_q;

	// One gain bit per cycle, LSB first; the sign bit weighs negative
	always_comb begin
		samp_ext = {samp_q[SAMPLE_BITS-1], samp_q};
		addend   = ctl.last ? -samp_ext : samp_ext;
		sum      = lo_q[0] ? hi_q + addend : hi_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			samp_q <= sample;
			hi_q   <= '0;
			lo_q   <= gain;
		end else if (ctl.run) begin
			hi_q <= {sum[SAMPLE_BITS], sum[SAMPLE_BITS:1]};
			lo_q <= {sum[0], lo_q[GAIN_BITS-1:1]};
		end
	end

	// Tracks an operation in flight; product is read after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (ctl.load)
			busy_q <= 1'b1;
		else if (ctl.last)
			busy_q <= 1'b0;
	end

	// floor(sample * gain / 2^GAIN_FRAC)
	assign prod = busy_q ? '0 : {hi_q, lo_q[GAIN_BITS-1:GAIN_FRAC]};

endmodule

>>> hw/rtl/ngl_div.sv
module ngl_div (
	input  logic                             clk,
	input  ngl_pkg::ser_ctl_t                ctl,
	input  logic [ngl_pkg::GAIN_BITS-1:0]    dividend,
	input  logic [ngl_pkg::LEN_BITS-1:0]     divisor,
	output logic [ngl_pkg::GAIN_BITS-1:0]    quotient
);
	import ngl_pkg::*;

	logic [LEN_BITS-1:0]  dvs_q;
	logic [LEN_BITS-1:0]  rem_q;
	logic [GAIN_BITS-1:0] quo_q;
	logic [LEN_BITS:0]    trial;
	logic                 ge;
	logic [LEN_BITS:0]    diff;

	// Restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[GAIN_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (ctl.run) begin
			rem_q <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
			quo_q <= {quo_q[GAIN_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

>>> hw/rtl/noise_gate_linear_ramp.sv
// Channel  | Signals                               | Direction
// frame    | frame_valid, frame_stall, frame       | in (stall out)
// result   | result_valid, result_stall, result    | out (stall in)
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in (ready out)
//
// A frame goes through the mix, crossing, load, run, finish and post states to its
// result in the output register; the next frame is taken once the state is back in idle.
// The run state does the 32-step bit-serial gain multiply and ramp divide.
// arst_n clears gain, ramp state and the output valid flag; registers take defaults.
// A stalled result holds; while it is held a finished frame waits in its last step.
module noise_gate_linear_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                frame_valid,
	output logic                                frame_stall,
	input  ngl_pkg::frame_t                     frame,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ngl_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ngl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ngl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import ngl_pkg::*;

	// Configuration
	logic [THR_BITS-1:0]   thr_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [LEN_BITS-1:0]   attack_q;
	logic [LEN_BITS-1:0]   release_q;
	logic                  monitor_q;
	logic                  stereo_q;

	// Gate state
	logic signed [GAIN_BITS-1:0] gain_q;
	logic signed [GAIN_BITS-1:0] step_q;
	logic [LEN_BITS-1:0]         cnt_q;
	logic [LEN_BITS-1:0]         len_q;
	logic [SAMPLE_BITS-1:0]      last_mag_q;

	// Per-frame working registers
	ngl_state_t                  state_q, state_d;
	logic signed [SAMPLE_BITS-1:0] left_q, right_q, mix_q;
	logic                        start_q;
	logic                        open_q;
	logic [LEN_BITS-1:0]         n_q;
	logic [STEP_BITS-1:0]        bit_q;
	result_t                     result_q;
	logic                        out_full_q;

	ser_ctl_t                    ctl;
	logic                        accept;
	logic                        post_fire;
	logic                        out_take;

	logic signed [SAMPLE_BITS:0]   pair_sum;
	logic signed [SAMPLE_BITS-1:0] mix;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [SAMPLE_BITS-1:0]        thr_ext;
	logic                          close_x, open_x;
	logic signed [DIFF_BITS-1:0]   target;
	logic signed [DIFF_BITS-1:0]   diff;
	logic [GAIN_BITS-1:0]          quotient;
	logic signed [DIFF_BITS-1:0]   q_signed;
	logic signed [PROD_BITS-1:0]   prod_l, prod_r;
	logic signed [SAMPLE_BITS-1:0] gated_l, gated_r;
	logic [LEN_BITS-1:0]           cnt_inc;
	result_t                       result_d;

	assign cfg_ready = 1'b1;
	assign accept    = frame_valid && !frame_stall;
	assign out_take  = out_full_q && !result_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_MIX;
			ST_MIX:   state_d = ST_CROSS;
			ST_CROSS: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_RUN;
			ST_RUN:   if (bit_q == STEP_BITS'(GAIN_BITS - 1)) state_d = ST_FIN;
			ST_FIN:   state_d = ST_POST;
			ST_POST:  if (!out_full_q || !result_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		frame_stall = (state_q != ST_IDLE);
		ctl.load    = (state_q == ST_LOAD);
		ctl.run     = (state_q == ST_RUN);
		ctl.last    = (state_q == ST_RUN) && (bit_q == STEP_BITS'(GAIN_BITS - 1));
		post_fire   = (state_q == ST_POST) && (!out_full_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RST;
			level_q   <= LEVEL_RST;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
			monitor_q <= 1'b0;
			stereo_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q     <= cfg_data[THR_BITS-1:0];
				CFG_LEVEL:     level_q   <= cfg_data[LEVEL_BITS-1:0];
				CFG_ATTACK:    attack_q  <= cfg_data[LEN_BITS-1:0];
				CFG_RELEASE:   release_q <= cfg_data[LEN_BITS-1:0];
				CFG_MONITOR:   monitor_q <= cfg_data[0];
				CFG_STEREO:    stereo_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Mono mix, magnitude and threshold crossings
	always_comb begin
		pair_sum = {left_q[SAMPLE_BITS-1], left_q} + {right_q[SAMPLE_BITS-1], right_q};
		mix      = stereo_q ? pair_sum[SAMPLE_BITS:1] : left_q;
		mag      = mix_q[SAMPLE_BITS-1] ? (~mix_q) + 1'b1 : mix_q;
		thr_ext  = {1'b0, thr_q};
		close_x  = (mag <= thr_ext) && (last_mag_q > thr_ext);
		open_x   = (mag >= thr_ext) && (last_mag_q < thr_ext);
	end

	// Ramp distance to the target
	always_comb begin
		target = open_q ? DIFF_BITS'(signed'({1'b0, 1'b1, {GAIN_FRAC{1'b0}}}))
		                : DIFF_BITS'(signed'({1'b0, level_q, {LEVEL_SHIFT{1'b0}}}));
		diff   = target - {gain_q[GAIN_BITS-1], gain_q};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= frame.sample_left;
			right_q <= frame.sample_right;
		end
		if (state_q == ST_MIX)
			mix_q <= mix;
		if (state_q == ST_CROSS) begin
			open_q <= open_x;
			n_q    <= open_x ? (attack_q == '0 ? LEN_BITS'(1) : attack_q)
			                 : (release_q == '0 ? LEN_BITS'(1) : release_q);
		end
	end

	// Serial step counter and crossing flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			start_q <= 1'b0;
		end else begin
			bit_q <= ctl.run ? bit_q + 1'b1 : '0;
			if (state_q == ST_CROSS)
				start_q <= close_x || open_x;
		end
	end

	ngl_div u_div (
		.clk      (clk),
		.ctl      (ctl),
		.dividend (diff[DIFF_BITS-1] ? GAIN_BITS'(-diff) : diff[GAIN_BITS-1:0]),
		.divisor  (n_q),
		.quotient (quotient)
	);

	ngl_mul u_mul_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (left_q),
		.gain   (gain_q),
		.prod   (prod_l)
	);

	ngl_mul u_mul_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (right_q),
		.gain   (gain_q),
		.prod   (prod_r)
	);

	// Magnitude of the previous frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_mag_q <= '0;
		else if (state_q == ST_CROSS)
			last_mag_q <= mag;
	end

	// Sign of the distance, captured with the divider load
	logic                 neg_ld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			neg_ld_q <= 1'b0;
		else if (ctl.load)
			neg_ld_q <= diff[DIFF_BITS-1];
	end

	// Output selection
	always_comb begin
		q_signed = neg_ld_q ? -DIFF_BITS'(signed'({1'b0, quotient}))
		                    : DIFF_BITS'(signed'({1'b0, quotient}));
		gated_l  = sat_sample(prod_l);
		gated_r  = sat_sample(prod_r);
		cnt_inc  = cnt_q + 1'b1;
		if (monitor_q) begin
			result_d.out_left  = mix_q;
			result_d.out_right = mix_q;
		end else begin
			result_d.out_left  = gated_l;
			result_d.out_right = stereo_q ? gated_r : gated_l;
		end
	end

	// Ramp state: new stage after the divide, gain step at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			step_q <= '0;
			cnt_q  <= '0;
			len_q  <= '0;
		end else if (state_q == ST_FIN) begin
			if (start_q) begin
				step_q <= sat_gain(q_signed);
				len_q  <= n_q;
				cnt_q  <= '0;
			end
		end else if (post_fire) begin
			gain_q <= sat_gain({gain_q[GAIN_BITS-1], gain_q} + {step_q[GAIN_BITS-1], step_q});
			if (cnt_inc == len_q) begin
				step_q <= '0;
				cnt_q  <= LEN_BITS'(1);
				len_q  <= '0;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_full_q <= 1'b0;
		else if (post_fire)
			out_full_q <= 1'b1;
		else if (out_take)
			out_full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (post_fire)
			result_q <= result_d;
	end

	assign result_valid = out_full_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// The quotient is used only after the last serial step
	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> $past(ctl.last))
		else $error("divide finished without its last step");

	// An idle ramp never carries a step
	a_idle_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) |-> (step_q == '0))
		else $error("gain step left over with no stage");

	// A finished frame lands in the output register
	a_post_lands: assert property (@(posedge clk) disable iff (!arst_n)
		post_fire |=> result_valid)
		else $error("result lost on write");

	// A stalled result stays put
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");
`endif

endmodule
